// ===== sv/hhq_pkg.sv =====
// hhq_pkg: widths, codes, reset values and shared types of the heightfield height query.
// No dependencies; every other file of the block imports it.
package hhq_pkg;

  localparam int GRID_SIDE_DEF = 128;

  localparam int COORD_W    = 32;
  localparam int INDEX_W    = 7;
  localparam int LEVEL_W    = 8;
  localparam int INV_W      = 32;
  localparam int DEPTH_W    = 24;
  localparam int HEIGHT_W   = 32;
  localparam int FRAC_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_BANKS   = 4;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [FRAC_W-1:0]         FRAC_ONE        = 17'h10000;
  localparam logic signed [COORD_W-1:0] OFFSET_RST      = 32'sd0;
  localparam logic [INV_W-1:0]          INV_CELL_RST    = 32'd65536;
  localparam logic [DEPTH_W-1:0]        DEPTH_SCALE_RST = 24'd65536;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 2'd0,
    CFG_OFFSET_Z    = 2'd1,
    CFG_INV_CELL    = 2'd2,
    CFG_DEPTH_SCALE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    logic              oob;
  } axis_res_t;

  typedef struct packed {
    logic              valid;
    logic              oob;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    logic              cx0;
    logic              cz0;
  } tri_info_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] terrain_height;
    logic                out_of_range;
  } out_word_t;

endpackage

// ===== sv/hhq_if.sv =====
// hhq_in_if, hhq_out_if: valid/ready channels of the heightfield height query.
// Depends on hhq_pkg for field widths and the operation code.
interface hhq_in_if import hhq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  op_t                         operation;
  logic [INDEX_W-1:0]          sample_column;
  logic [INDEX_W-1:0]          sample_row;
  logic [LEVEL_W-1:0]          sample_level;
  logic signed [COORD_W-1:0]   world_x;
  logic signed [COORD_W-1:0]   world_z;

  modport source (
    output valid, operation, sample_column, sample_row, sample_level, world_x, world_z,
    input  ready
  );
  modport sink (
    input  valid, operation, sample_column, sample_row, sample_level, world_x, world_z,
    output ready
  );
endinterface

interface hhq_out_if import hhq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] terrain_height;
  logic                out_of_range;

  modport source (output valid, terrain_height, out_of_range, input ready);
  modport sink   (input valid, terrain_height, out_of_range, output ready);
endinterface

// ===== sv/hhq_ram.sv =====
// hhq_ram: generic single-write, single-read RAM with registered read data.
// Depends on hhq_pkg for default widths only.
module hhq_ram import hhq_pkg::*; #(
  parameter int WIDTH = LEVEL_W,
  parameter int DEPTH = GRID_SIDE_DEF * GRID_SIDE_DEF / NUM_BANKS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    rdata_r <= mem_r[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== sv/hhq_axis.sv =====
// hhq_axis: one axis of the query: origin subtract, magnitude, scale by cells per unit,
// then split into a clamped cell index and fraction. Depends on hhq_pkg.
module hhq_axis import hhq_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  localparam int CELL_W = $clog2(GRID_SIDE)
) (
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] world_i,
  input  logic signed [COORD_W-1:0] offset_i,
  input  logic [INV_W-1:0]          inv_i,
  output logic [CELL_W-1:0]         cell_o,
  output axis_res_t                 res_o
);

  logic signed [COORD_W:0]     t_r, t_nxt;
  logic [COORD_W-1:0]          mag_r, mag_nxt;
  logic                        neg2_r, neg2_nxt;
  logic [COORD_W+INV_W-1:0]    prod_r, prod_nxt;
  logic                        neg3_r, neg3_nxt;
  logic [COORD_W-1:0]          whole;
  logic                        lo_oob, hi_oob;

  assign t_nxt    = {world_i[COORD_W-1], world_i} - {offset_i[COORD_W-1], offset_i};
  assign neg2_nxt = t_r[COORD_W];
  assign mag_nxt  = t_r[COORD_W] ? COORD_W'(-t_r) : t_r[COORD_W-1:0];
  assign prod_nxt = mag_r * inv_i;
  assign neg3_nxt = neg2_r;

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    mag_r  <= mag_nxt;
    neg2_r <= neg2_nxt;
    prod_r <= prod_nxt;
    neg3_r <= neg3_nxt;
  end

  // negative offsets stay in the grid only when the product is exactly zero
  assign whole  = prod_r[COORD_W+INV_W-1:INV_W];
  assign lo_oob = neg3_r && (prod_r != '0);
  assign hi_oob = !neg3_r && (whole > COORD_W'(GRID_SIDE - 2));

  always_comb begin
    priority if (hi_oob) begin
      cell_o     = CELL_W'(GRID_SIDE - 2);
      res_o.frac = FRAC_ONE;
    end else if (lo_oob) begin
      cell_o     = '0;
      res_o.frac = '0;
    end else begin
      cell_o     = whole[CELL_W-1:0];
      res_o.frac = {1'b0, prod_r[INV_W-1:INV_W-FRAC_W+1]};
    end
    res_o.oob = lo_oob || hi_oob;
  end

endmodule

// ===== sv/hhq_interp.sv =====
// hhq_interp: triangle choice and plane interpolation of the corner samples, then
// scaling by depth. Two register stages. Depends on hhq_pkg.
module hhq_interp import hhq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tri_info_t          info_i,
  input  level_t             rdata_i [NUM_BANKS],
  input  logic [DEPTH_W-1:0] depth_i,
  output logic               word_valid_o,
  output out_word_t          word_o
);

  localparam int SUM_W = LEVEL_W + FRAC_W + 3;
  localparam int S_W   = LEVEL_W + FRAC_W - 1;

  level_t                    h00, h10, h01, h11;
  logic                      upper;
  logic [FRAC_W-1:0]         wa, wb;
  logic signed [LEVEL_W+1:0] d1, d2;
  logic signed [SUM_W-1:0]   m1, m2, sum;

  logic                      s_valid_r, s_valid_nxt;
  logic                      s_oob_r, s_oob_nxt;
  logic [S_W-1:0]            s_r, s_nxt;
  logic [S_W+DEPTH_W-1:0]    scaled;
  logic                      word_valid_r, word_valid_nxt;
  out_word_t                 word_r, word_nxt;

  assign h00 = rdata_i[{info_i.cx0, info_i.cz0}];
  assign h10 = rdata_i[{~info_i.cx0, info_i.cz0}];
  assign h01 = rdata_i[{info_i.cx0, ~info_i.cz0}];
  assign h11 = rdata_i[{~info_i.cx0, ~info_i.cz0}];

  assign upper = info_i.fz > info_i.fx;
  assign wa    = upper ? info_i.fz : info_i.fx;
  assign wb    = upper ? info_i.fx : info_i.fz;
  assign d1    = upper ? ($signed({2'b00, h01}) - $signed({2'b00, h00}))
                       : ($signed({2'b00, h10}) - $signed({2'b00, h00}));
  assign d2    = upper ? ($signed({2'b00, h11}) - $signed({2'b00, h01}))
                       : ($signed({2'b00, h11}) - $signed({2'b00, h10}));
  assign m1    = $signed({1'b0, wa}) * d1;
  assign m2    = $signed({1'b0, wb}) * d2;
  assign sum   = $signed({4'b0000, h00, 16'h0000}) + m1 + m2;

  assign s_valid_nxt = info_i.valid;
  assign s_oob_nxt   = info_i.oob;
  assign s_nxt       = sum[SUM_W-1] ? '0 : sum[S_W-1:0];

  assign scaled                  = s_r * depth_i;
  assign word_valid_nxt          = s_valid_r;
  assign word_nxt.terrain_height = scaled[S_W+DEPTH_W-1:FRAC_W-1];
  assign word_nxt.out_of_range   = s_oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      word_valid_r <= 1'b0;
    end else begin
      s_valid_r    <= s_valid_nxt;
      word_valid_r <= word_valid_nxt;
    end
    s_oob_r <= s_oob_nxt;
    s_r     <= s_nxt;
    word_r  <= word_nxt;
  end

  assign word_valid_o = word_valid_r;
  assign word_o       = word_r;

endmodule

// ===== sv/hhq_outq.sv =====
// hhq_outq: result queue in front of the output channel, with a credit count of
// queries in flight that gates input acceptance. Depends on hhq_pkg and hhq_if.
module hhq_outq import hhq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take_i,
  input  logic      push_i,
  input  out_word_t word_i,
  output logic      room_o,
  hhq_out_if.source out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_word_t        q_r [QUEUE_DEPTH];
  out_word_t        q_nxt [QUEUE_DEPTH];
  logic [PTR_W:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] credit_r, credit_nxt;
  logic             pop;

  assign out_ch.valid          = wr_ptr_r != rd_ptr_r;
  assign out_ch.terrain_height = q_r[rd_ptr_r[PTR_W-1:0]].terrain_height;
  assign out_ch.out_of_range   = q_r[rd_ptr_r[PTR_W-1:0]].out_of_range;
  assign pop                   = out_ch.valid && out_ch.ready;
  assign room_o                = credit_r < CNT_W'(QUEUE_DEPTH);

  always_comb begin
    q_nxt = q_r;
    if (push_i) begin
      q_nxt[wr_ptr_r[PTR_W-1:0]] = word_i;
    end
    wr_ptr_nxt = wr_ptr_r + (PTR_W + 1)'(push_i);
    rd_ptr_nxt = rd_ptr_r + (PTR_W + 1)'(pop);
    unique case ({take_i, pop})
      2'b10:   credit_nxt = credit_r + 1'b1;
      2'b01:   credit_nxt = credit_r - 1'b1;
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      credit_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      credit_r <= credit_nxt;
    end
    q_r <= q_nxt;
  end

endmodule

// ===== sv/heightfield_height_query.sv =====
// heightfield_height_query: top level; configuration registers, control pipeline,
// four banked heightmap RAMs. Depends on hhq_pkg, hhq_if, hhq_ram, hhq_axis,
// hhq_interp and hhq_outq.
//
// One word is accepted every cycle while fewer than eight queries are outstanding, writes
// and queries freely mixed and kept in order. A query's result passes through three axis
// stages (subtract, magnitude, 32x32 scale), the registered read of the four heightmap
// banks, the interpolation stage, the depth multiply and the output queue. The heightmap
// is split by column and row parity into four RAMs so the four corners of a cell are read
// in the same cycle. A sample write lands at the same stage where queries read, so a later
// query always sees it. Up to eight queries may be in flight or waiting; ready drops only
// when all eight results are still untaken. The heightmap has no reset and no clearing
// pass: read only samples that have been written.
module heightfield_height_query import hhq_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hhq_in_if.sink                in_ch,
  hhq_out_if.source             out_ch
);

  localparam int CELL_W     = $clog2(GRID_SIDE);
  localparam int HALF       = (GRID_SIDE + 1) / 2;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [INDEX_W-1:0] col;
    logic [INDEX_W-1:0] row;
    level_t             level;
  } ctl_t;

  logic signed [COORD_W-1:0] offset_x_r, offset_x_nxt;
  logic signed [COORD_W-1:0] offset_z_r, offset_z_nxt;
  logic [INV_W-1:0]          inv_cell_r, inv_cell_nxt;
  logic [DEPTH_W-1:0]        depth_scale_r, depth_scale_nxt;

  ctl_t                      ctl1_r, ctl1_nxt;
  ctl_t                      ctl2_r;
  ctl_t                      ctl3_r;
  tri_info_t                 tri_r, tri_nxt;

  logic                      in_acc, query_acc, room;
  logic [CELL_W-1:0]         cx, cz;
  axis_res_t                 ax, az;
  logic                      wr_en;
  logic [BANK_AW-1:0]        wr_addr;
  logic [NUM_BANKS-1:0]      bank_we;
  logic [BANK_AW-1:0]        bank_raddr [NUM_BANKS];
  level_t                    bank_rdata [NUM_BANKS];
  logic                      word_valid;
  out_word_t                 word;

  always_comb begin
    offset_x_nxt    = offset_x_r;
    offset_z_nxt    = offset_z_r;
    inv_cell_nxt    = inv_cell_r;
    depth_scale_nxt = depth_scale_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_X:    offset_x_nxt    = cfg_wdata;
        CFG_OFFSET_Z:    offset_z_nxt    = cfg_wdata;
        CFG_INV_CELL:    inv_cell_nxt    = cfg_wdata;
        CFG_DEPTH_SCALE: depth_scale_nxt = cfg_wdata[DEPTH_W-1:0];
      endcase
    end
  end

  assign in_ch.ready = room;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign query_acc   = in_acc && (in_ch.operation == OP_QUERY);

  assign ctl1_nxt.valid = in_acc;
  assign ctl1_nxt.op    = in_ch.operation;
  assign ctl1_nxt.col   = in_ch.sample_column;
  assign ctl1_nxt.row   = in_ch.sample_row;
  assign ctl1_nxt.level = in_ch.sample_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= OFFSET_RST;
      offset_z_r    <= OFFSET_RST;
      inv_cell_r    <= INV_CELL_RST;
      depth_scale_r <= DEPTH_SCALE_RST;
      ctl1_r        <= '0;
      ctl2_r        <= '0;
      ctl3_r        <= '0;
      tri_r         <= '0;
    end else begin
      offset_x_r    <= offset_x_nxt;
      offset_z_r    <= offset_z_nxt;
      inv_cell_r    <= inv_cell_nxt;
      depth_scale_r <= depth_scale_nxt;
      ctl1_r        <= ctl1_nxt;
      ctl2_r        <= ctl1_r;
      ctl3_r        <= ctl2_r;
      tri_r         <= tri_nxt;
    end
  end

  hhq_axis #(.GRID_SIDE(GRID_SIDE)) u_axis_x (
    .clk      (clk),
    .world_i  (in_ch.world_x),
    .offset_i (offset_x_r),
    .inv_i    (inv_cell_r),
    .cell_o   (cx),
    .res_o    (ax)
  );

  hhq_axis #(.GRID_SIDE(GRID_SIDE)) u_axis_z (
    .clk      (clk),
    .world_i  (in_ch.world_z),
    .offset_i (offset_z_r),
    .inv_i    (inv_cell_r),
    .cell_o   (cz),
    .res_o    (az)
  );

  // drop writes outside the grid
  assign wr_en   = ctl3_r.valid && (ctl3_r.op == OP_WRITE) &&
                   (int'(ctl3_r.col) < GRID_SIDE) && (int'(ctl3_r.row) < GRID_SIDE);
  assign wr_addr = BANK_AW'((int'(ctl3_r.col) >> 1) * HALF + (int'(ctl3_r.row) >> 1));

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    localparam logic [1:0] BID = 2'(g);
    logic [CELL_W-1:0] col_sel, row_sel;

    assign col_sel       = (cx[0] == BID[1]) ? cx : cx + 1'b1;
    assign row_sel       = (cz[0] == BID[0]) ? cz : cz + 1'b1;
    assign bank_raddr[g] = BANK_AW'((int'(col_sel) >> 1) * HALF + (int'(row_sel) >> 1));
    assign bank_we[g]    = wr_en && ({ctl3_r.col[0], ctl3_r.row[0]} == BID);

    hhq_ram #(.WIDTH(LEVEL_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk     (clk),
      .we_i    (bank_we[g]),
      .waddr_i (wr_addr),
      .wdata_i (ctl3_r.level),
      .raddr_i (bank_raddr[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  assign tri_nxt.valid = ctl3_r.valid && (ctl3_r.op == OP_QUERY);
  assign tri_nxt.oob   = ax.oob || az.oob;
  assign tri_nxt.fx    = ax.frac;
  assign tri_nxt.fz    = az.frac;
  assign tri_nxt.cx0   = cx[0];
  assign tri_nxt.cz0   = cz[0];

  hhq_interp u_interp (
    .clk          (clk),
    .rst_n        (rst_n),
    .info_i       (tri_r),
    .rdata_i      (bank_rdata),
    .depth_i      (depth_scale_r),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  hhq_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (query_acc),
    .push_i (word_valid),
    .word_i (word),
    .room_o (room),
    .out_ch (out_ch)
  );

  a_query_reaches_read: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |-> ##4 tri_r.valid)
    else $error("accepted query did not reach the bank read stage");

  a_single_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("sample write decoded to more than one bank");

  a_read_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    tri_r.valid |-> ##2 word_valid)
    else $error("bank read did not produce a result word two cycles later");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for heightfield_height_query. Loads heightmap samples and sends
// height queries over valid/ready words, predicting each height and clamp flag in order.
// Depends on hhq_pkg, the hhq_in_if/hhq_out_if interfaces and the block's RTL.
module tb;
  import hhq_pkg::*;

  localparam int SIDE = GRID_SIDE_DEF;

  class height_board;
    logic [LEVEL_W-1:0] level_map [SIDE*SIDE];
    bit                 level_set [SIDE*SIDE];
    int                 off_x;
    int                 off_z;
    int unsigned        inv;
    int unsigned        depth;
    out_word_t          heights_due [$];
    int                 n_writes;
    int                 n_queries;
    int                 n_clamped;
    int                 n_checked;
    int                 errors;

    function new();
      off_x = OFFSET_RST;
      off_z = OFFSET_RST;
      inv   = INV_CELL_RST;
      depth = DEPTH_SCALE_RST;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_OFFSET_X:    off_x = $signed(v);
        CFG_OFFSET_Z:    off_z = $signed(v);
        CFG_INV_CELL:    inv = v;
        CFG_DEPTH_SCALE: depth = v[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    // floor of t * inv in Q32.32, then clamp to the grid
    function void grid_cell(longint t, output int unsigned cell_idx, output int unsigned frac,
                            inout bit oob);
      bit [63:0] mag;
      bit [63:0] prod;
      longint    idx;
      bit [32:0] rem;
      mag  = (t < 0) ? 64'(-t) : 64'(t);
      prod = mag * {32'd0, inv};
      if (t >= 0) begin
        idx = longint'(prod[63:32]);
        rem = {1'b0, prod[31:0]};
      end else if (prod[31:0] == 32'd0) begin
        idx = -longint'(prod[63:32]);
        rem = '0;
      end else begin
        idx = -longint'(prod[63:32]) - 1;
        rem = 33'h1_0000_0000 - {1'b0, prod[31:0]};
      end
      if (idx < 0) begin
        cell_idx = 0;
        frac     = 0;
        oob      = 1'b1;
      end else if (idx > SIDE - 2) begin
        cell_idx = SIDE - 2;
        frac     = FRAC_ONE;
        oob      = 1'b1;
      end else begin
        cell_idx = int'(idx);
        frac     = rem[31:16];
      end
    endfunction

    function void note_word(op_t op, logic [INDEX_W-1:0] col, logic [INDEX_W-1:0] row,
                            logic [LEVEL_W-1:0] lvl, logic signed [COORD_W-1:0] wx,
                            logic signed [COORD_W-1:0] wz);
      int unsigned cx, cz, fx, fz;
      bit          oob;
      longint      h00, h01, h10, h11, s;
      bit [63:0]   h;
      out_word_t   w;
      if (op == OP_WRITE) begin
        level_map[col * SIDE + row] = lvl;
        level_set[col * SIDE + row] = 1'b1;
        n_writes++;
        return;
      end
      oob = 1'b0;
      grid_cell(longint'(wx) - longint'(off_x), cx, fx, oob);
      grid_cell(longint'(wz) - longint'(off_z), cz, fz, oob);
      h00 = level_map[cx * SIDE + cz];
      h01 = level_map[cx * SIDE + cz + 1];
      h10 = level_map[(cx + 1) * SIDE + cz];
      h11 = level_map[(cx + 1) * SIDE + cz + 1];
      if (fz > fx)
        s = h00 * 65536 + longint'(fz) * (h01 - h00) + longint'(fx) * (h11 - h01);
      else
        s = h00 * 65536 + longint'(fx) * (h10 - h00) + longint'(fz) * (h11 - h10);
      if (s < 0)
        s = 0;
      h = (64'(s) * 64'(depth)) >> 16;
      w.terrain_height = (h > 64'hFFFF_FFFF) ? '1 : h[HEIGHT_W-1:0];
      w.out_of_range   = oob;
      heights_due = {heights_due, w};
      n_queries++;
      if (oob)
        n_clamped++;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [HEIGHT_W-1:0] height, logic oob);
      out_word_t w;
      if (heights_due.size() == 0) begin
        report($sformatf("result word %h/%b with no query pending", height, oob));
        return;
      end
      w = heights_due.pop_front();
      if (height !== w.terrain_height)
        report($sformatf("result %0d: terrain_height %h, want %h", n_checked, height,
                         w.terrain_height));
      if (oob !== w.out_of_range)
        report($sformatf("result %0d: out_of_range %b, want %b", n_checked, oob,
                         w.out_of_range));
      n_checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hhq_in_if  in_ch ();
  hhq_out_if out_ch ();

  heightfield_height_query u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  height_board sb;
  bit          idling   = 1'b1;
  bit          calm_in  = 1'b0;
  bit          calm_out = 1'b0;
  int          n_items  = 0;
  int          n_settings = 1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idling && !calm_out && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.terrain_height, out_ch.out_of_range);
  end

  task automatic send_word(op_t op, logic [INDEX_W-1:0] col, logic [INDEX_W-1:0] row,
                           logic [LEVEL_W-1:0] lvl, logic [COORD_W-1:0] wx,
                           logic [COORD_W-1:0] wz);
    @(negedge clk);
    if (idling && !calm_in && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.operation     = op;
    in_ch.sample_column = col;
    in_ch.sample_row    = row;
    in_ch.sample_level  = lvl;
    in_ch.world_x       = wx;
    in_ch.world_z       = wz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(op, col, row, lvl, $signed(wx), $signed(wz));
    n_items++;
  endtask

  // load any unwritten corner of the cell first, then query
  task automatic query_at(logic [COORD_W-1:0] wx, logic [COORD_W-1:0] wz);
    int unsigned cx, cz, fx, fz;
    bit          oob;
    sb.grid_cell(longint'($signed(wx)) - longint'(sb.off_x), cx, fx, oob);
    sb.grid_cell(longint'($signed(wz)) - longint'(sb.off_z), cz, fz, oob);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (!sb.level_set[(cx + i) * SIDE + cz + j])
          send_word(OP_WRITE, 7'(cx + i), 7'(cz + j), 8'($urandom), $urandom, $urandom);
    send_word(OP_QUERY, 7'($urandom), 7'($urandom), 8'($urandom), wx, wz);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.heights_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [31:0] ox, logic [31:0] oz, logic [31:0] inv,
                           logic [31:0] depth);
    drain();
    put_reg(CFG_OFFSET_X, ox);
    put_reg(CFG_OFFSET_Z, oz);
    put_reg(CFG_INV_CELL, inv);
    put_reg(CFG_DEPTH_SCALE, depth);
    @(negedge clk);
    cfg_we = 1'b0;
    n_settings++;
  endtask

  // world position for grid coordinate g (cells, Q16.16) under the current setting
  function automatic logic [COORD_W-1:0] place(longint g, int off);
    if (sb.inv == 0)
      return $urandom;
    return 32'(longint'(off) + (g <<< 16) / longint'(sb.inv));
  endfunction

  function automatic longint edge_coord();
    case ($urandom_range(0, 5))
      0:       return -longint'($urandom_range(1, 5 * 65536));
      1:       return 0;
      2:       return 126 * 65536 + 65535;
      3:       return 127 * 65536;
      4:       return 128 * 65536;
      default: return longint'($urandom_range(0, SIDE - 1)) * 65536;
    endcase
  endfunction

  task automatic run_batch(int quota);
    int     stop;
    int     pick;
    int     wx0, wz0;
    longint gx, gz;
    stop = n_items + quota;
    wx0  = $urandom_range(0, SIDE - 17);
    wz0  = $urandom_range(0, SIDE - 17);
    while (n_items < stop) begin
      if ($urandom_range(0, 39) == 0) begin
        calm_in  = ($urandom_range(0, 2) == 0);
        calm_out = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        drain();
      end else if (pick < 25) begin
        send_word(OP_WRITE, 7'($urandom), 7'($urandom), 8'($urandom), $urandom, $urandom);
      end else if (pick < 35) begin
        query_at($urandom, $urandom);
      end else if (pick < 45) begin
        query_at(place(edge_coord(), sb.off_x), place(edge_coord(), sb.off_z));
      end else begin
        gx = longint'(wx0 + $urandom_range(0, 15)) * 65536 + $urandom_range(0, 65535);
        gz = longint'(wz0 + $urandom_range(0, 15)) * 65536
           + (($urandom_range(0, 7) == 0) ? gx % 65536 : longint'($urandom_range(0, 65535)));
        query_at(place(gx, sb.off_x), place(gz, sb.off_z));
      end
    end
  endtask

  initial begin
    sb                  = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_OFFSET_X;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_WRITE;
    in_ch.sample_column = '0;
    in_ch.sample_row    = '0;
    in_ch.sample_level  = '0;
    in_ch.world_x       = '0;
    in_ch.world_z       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner cells with full-scale and zero samples
    for (int c = 0; c < 2; c++)
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          send_word(OP_WRITE, 7'(c * 126 + i), 7'(c * 126 + j),
                    (((i == j) ? 1 : 0) ^ c) ? 8'hFF : 8'h00, $urandom, $urandom);
    query_at(32'h0000_4000, 32'h0000_C000);
    query_at(32'h0000_C000, 32'h0000_4000);
    query_at(32'h0000_8000, 32'h0000_8000);
    query_at(32'h0000_0000, 32'h0000_0000);
    query_at(-32'sh0001_8000, 32'h0000_8000);
    query_at(32'h0000_8000, -32'sh0003_0000);
    query_at(32'h00C8_0000, 32'h007E_8000);
    query_at(32'h007E_8000, 32'h007F_0000);
    query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query_at(32'h8000_0000, 32'h8000_0000);
    query_at(32'h007E_FFFF, 32'h007E_FFFF);

    run_batch(200);
    configure($urandom_range(0, 32'h20_0000), -$urandom_range(0, 32'h20_0000),
              32'h0002_0000, 32'h00FF_FFFF);
    run_batch(150);
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    run_batch(120);
    configure($urandom, $urandom, 32'h0000_0000, $urandom_range(0, 32'hFF_FFFF));
    run_batch(80);
    configure($urandom_range(0, 32'h40_0000), -$urandom_range(0, 32'h40_0000),
              $urandom_range(32'h4000, 32'h4_0000), $urandom_range(0, 32'hFF_FFFF));
    run_batch(150);

    // hold both sides steady for the last stretch
    configure(-$urandom_range(0, 32'h10_0000), $urandom_range(0, 32'h10_0000),
              $urandom_range(32'h8000, 32'h3_0000), $urandom_range(0, 32'hFF_FFFF));
    idling = 1'b0;
    run_batch(200);
    drain();
    repeat (12) @(posedge clk);

    $display("Sent %0d words: %0d sample writes, %0d height queries (%0d clamped).",
             n_items, sb.n_writes, sb.n_queries, sb.n_clamped);
    $display("Checked %0d results across %0d register settings.", sb.n_checked, n_settings);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/hhq_pkg.sv
sv/hhq_if.sv
sv/hhq_ram.sv
sv/hhq_axis.sv
sv/hhq_interp.sv
sv/hhq_outq.sv
sv/heightfield_height_query.sv
dv/tb.sv
